@@ hdl/csr_mv_pkg.sv @@
// csr_mv_pkg: shared types, field widths and register codes for the csr sparse matvec block
// no dependencies; used by csr_sparse_matvec_top
`timescale 1ns / 1ps
`default_nettype none

package csr_mv_pkg;

    // input item fields
    localparam int INDEX_W = 12;
    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;

    // result item fields
    localparam int ROW_W = 20;
    localparam int SUM_W = 64;

    // packed stream widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 2;

    // configuration registers
    localparam int NUM_ROWS_W = 21;
    localparam int NUM_COLS_W = 13;
    localparam int CFG_DATA_W = 21;

    localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RESET = 21'd1048576;
    localparam logic [NUM_COLS_W-1:0] NUM_COLS_RESET = 13'd4096;

    localparam int DEFAULT_VECTOR_DEPTH = 4096;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_NONZERO = 2'd1,
        CMD_EMPTY   = 2'd2
    } cmd_t;

    typedef enum logic {
        CFG_NUM_ROWS = 1'b0,
        CFG_NUM_COLS = 1'b1
    } cfg_idx_t;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

`default_nettype wire

@@ hdl/csr_sparse_matvec_top.sv @@
// csr_sparse_matvec_top: streaming csr sparse matrix-vector multiply, q16.16 in, q32.32 out
// depends on csr_mv_pkg
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tdata {value, index}, tuser command, tlast last_in_row
// m_*       out  m_tvalid/m_tready    tdata {row_sum, row_index}, tuser {index_error,
//                                     saturated}, tlast last_row
// cfg_*     in   cfg_we (no wait)     cfg_addr register index, cfg_wdata value
//
// one item per cycle unless output stalls; m_tvalid rises after the transfer that ends a row
//   (store read at the transfer, multiply, then accumulate into the output register)
// a load and a nonzero to the same column in back-to-back cycles need no interlock
// synchronous reset clears row state and valids and restores both registers; the vector
//   store is not cleared and holds garbage until loaded
// a held result stops input once a row end waits at accumulate and stage 1 is full

module csr_sparse_matvec_top #(
    parameter int VECTOR_DEPTH = csr_mv_pkg::DEFAULT_VECTOR_DEPTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [csr_mv_pkg::S_TDATA_W-1:0]    s_tdata,   // index[11:0], value[43:12]
    input  wire logic [csr_mv_pkg::CMD_W-1:0]        s_tuser,   // command[1:0]
    input  wire logic                                s_tlast,   // last_in_row

    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [csr_mv_pkg::M_TDATA_W-1:0]         m_tdata,   // row_index[19:0], row_sum[83:20]
    output logic [csr_mv_pkg::M_TUSER_W-1:0]         m_tuser,   // saturated[0], index_error[1]
    output logic                                     m_tlast,   // last_row

    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_addr,
    input  wire logic [csr_mv_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int IdxW  = csr_mv_pkg::INDEX_W;
    localparam int ValW  = csr_mv_pkg::VALUE_W;
    localparam int SumW  = csr_mv_pkg::SUM_W;
    localparam int RowW  = csr_mv_pkg::ROW_W;
    localparam int NrW   = csr_mv_pkg::NUM_ROWS_W;
    localparam int NcW   = csr_mv_pkg::NUM_COLS_W;
    localparam int AddrW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int ExtW  = (AddrW > IdxW) ? AddrW : IdxW;
    localparam int DepW  = $clog2(VECTOR_DEPTH + 1) + 1;
    localparam int CmpW  = (DepW > IdxW + 1) ? DepW : IdxW + 1;
    localparam int PadW  = csr_mv_pkg::M_TDATA_W - SumW - RowW;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [NrW-1:0] num_rows_reg;
    logic [NcW-1:0] num_cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= csr_mv_pkg::NUM_ROWS_RESET;
            num_cols_reg <= csr_mv_pkg::NUM_COLS_RESET;
        end else if (cfg_we) begin
            case (csr_mv_pkg::cfg_idx_t'(cfg_addr))
                csr_mv_pkg::CFG_NUM_ROWS: num_rows_reg <= cfg_wdata[NrW-1:0];
                csr_mv_pkg::CFG_NUM_COLS: num_cols_reg <= cfg_wdata[NcW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input unpack and column range check
    // ------------------------------------------------------------------
    logic [IdxW-1:0]     in_index;
    logic [ValW-1:0]     in_value;
    csr_mv_pkg::cmd_t    in_cmd;
    logic [ExtW-1:0]     in_index_ext;
    logic [AddrW-1:0]    in_addr;
    logic                in_depth_ok;
    logic                in_col_bad;
    logic                s_fire;

    assign in_index     = s_tdata[IdxW-1:0];
    assign in_value     = s_tdata[IdxW+ValW-1:IdxW];
    assign in_cmd       = csr_mv_pkg::cmd_t'(s_tuser);
    assign in_index_ext = ExtW'(in_index);
    assign in_addr      = in_index_ext[AddrW-1:0];
    assign in_depth_ok  = CmpW'(in_index) < CmpW'(VECTOR_DEPTH);
    // out of range if at or above num_cols, or past the store
    assign in_col_bad   = ({1'b0, in_index} >= num_cols_reg) || !in_depth_ok;
    assign s_fire       = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // vector store: write and registered read at input transfer
    // ------------------------------------------------------------------
    logic [ValW-1:0] vec_mem [VECTOR_DEPTH];
    logic [ValW-1:0] x_rd_reg;

    always_ff @(posedge aclk) begin
        if (s_fire && in_cmd == csr_mv_pkg::CMD_LOAD && in_depth_ok) begin
            vec_mem[in_addr] <= in_value;
        end
        if (s_fire && in_cmd == csr_mv_pkg::CMD_NONZERO && !in_col_bad) begin
            x_rd_reg <= vec_mem[in_addr];
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: stage 1 (read data), stage 2 (product), output register
    // ------------------------------------------------------------------
    logic                v1_reg, v2_reg, m_valid_reg;
    csr_mv_pkg::cmd_t    cmd1_reg, cmd2_reg;
    logic                last1_reg, last2_reg;
    logic                bad1_reg, bad2_reg;
    logic [ValW-1:0]     val1_reg;
    logic signed [SumW-1:0] prod_reg;

    logic out_free, emit2, adv2, ready2, adv1;

    assign out_free = !m_valid_reg || m_tready;
    assign emit2    = (cmd2_reg == csr_mv_pkg::CMD_EMPTY) ||
                      (cmd2_reg == csr_mv_pkg::CMD_NONZERO && last2_reg);
    // the accumulate stage retires unless it has a result and the output is held
    assign adv2     = v2_reg && (!emit2 || out_free);
    assign ready2   = !v2_reg || adv2;
    assign adv1     = v1_reg && ready2;
    assign s_tready = !v1_reg || ready2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                v1_reg <= 1'b1;
            end else if (adv1) begin
                v1_reg <= 1'b0;
            end
            if (adv1) begin
                v2_reg <= 1'b1;
            end else if (adv2) begin
                v2_reg <= 1'b0;
            end
        end
    end

    // payload of stages 1 and 2, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd1_reg  <= in_cmd;
            last1_reg <= s_tlast;
            bad1_reg  <= in_col_bad;
            val1_reg  <= in_value;
        end
        if (adv1) begin
            cmd2_reg  <= cmd1_reg;
            last2_reg <= last1_reg;
            bad2_reg  <= bad1_reg;
            prod_reg  <= $signed(val1_reg) * $signed(x_rd_reg);
        end
    end

    // ------------------------------------------------------------------
    // accumulate stage: saturating row sum, row flags, row counter
    // ------------------------------------------------------------------
    logic signed [SumW-1:0] acc_reg, acc_next;
    logic                   sat_reg, sat_next;
    logic                   err_reg, err_next;
    logic [RowW-1:0]        row_cnt_reg, row_cnt_next;

    logic signed [SumW-1:0] acc_add, acc_nz, acc_emit;
    logic                   add_ovf, sat_nz, err_nz, sat_emit, err_emit;
    logic [NrW-1:0]         row_plus_one;
    logic                   last_row_hit;

    always_comb begin
        acc_add  = acc_reg + prod_reg;
        // overflow when both addends share a sign the sum does not
        add_ovf  = (acc_reg[SumW-1] == prod_reg[SumW-1]) &&
                   (acc_add[SumW-1] != acc_reg[SumW-1]);
        if (bad2_reg) begin
            acc_nz = acc_reg;
            sat_nz = sat_reg;
            err_nz = 1'b1;
        end else begin
            acc_nz = add_ovf ? (acc_reg[SumW-1] ? csr_mv_pkg::SUM_MIN : csr_mv_pkg::SUM_MAX)
                             : acc_add;
            sat_nz = sat_reg || add_ovf;
            err_nz = err_reg;
        end

        // an empty row reports the row state as it stands
        if (cmd2_reg == csr_mv_pkg::CMD_NONZERO) begin
            acc_emit = acc_nz;
            sat_emit = sat_nz;
            err_emit = err_nz;
        end else begin
            acc_emit = acc_reg;
            sat_emit = sat_reg;
            err_emit = err_reg;
        end

        row_plus_one = NrW'(row_cnt_reg) + NrW'(1);
        last_row_hit = (row_plus_one == num_rows_reg) && (num_rows_reg != '0);

        acc_next     = acc_reg;
        sat_next     = sat_reg;
        err_next     = err_reg;
        row_cnt_next = row_cnt_reg;

        case (cmd2_reg)
            csr_mv_pkg::CMD_LOAD: begin
                acc_next     = '0;
                sat_next     = 1'b0;
                err_next     = 1'b0;
                row_cnt_next = '0;
            end
            csr_mv_pkg::CMD_NONZERO: begin
                acc_next = acc_nz;
                sat_next = sat_nz;
                err_next = err_nz;
            end
            default: ;
        endcase

        // end of row: clear the row and step the count, back to zero after the final row
        if (emit2) begin
            acc_next     = '0;
            sat_next     = 1'b0;
            err_next     = 1'b0;
            row_cnt_next = last_row_hit ? '0 : row_plus_one[RowW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            sat_reg     <= 1'b0;
            err_reg     <= 1'b0;
            row_cnt_reg <= '0;
        end else if (adv2) begin
            acc_reg     <= acc_next;
            sat_reg     <= sat_next;
            err_reg     <= err_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [csr_mv_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [csr_mv_pkg::M_TUSER_W-1:0] m_user_reg;
    logic                             m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv2 && emit2) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && emit2) begin
            m_data_reg <= {{PadW{1'b0}}, acc_emit, row_cnt_reg};
            m_user_reg <= {err_emit, sat_emit};
            m_last_reg <= last_row_hit;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_load_restarts_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv2 && cmd2_reg == csr_mv_pkg::CMD_LOAD) |=> (row_cnt_reg == '0 && acc_reg == '0))
        else $error("load did not restart the row state");

    a_final_row_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv2 && emit2 && last_row_hit) |=> (row_cnt_reg == '0 && m_tlast))
        else $error("final row did not wrap the row counter");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && m_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

    a_result_from_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(adv2 && emit2))
        else $error("result raised without a row end");

endmodule

`default_nettype wire
